// ===== rtl/alt_pkg.sv =====
`timescale 1ns / 1ps

package alt_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WIDE_W   = (CNT_W > 8) ? CNT_W : 8;

    // operation codes
    localparam logic [3:0] MODE_SORTED_INS = 4'd0;
    localparam logic [3:0] MODE_FRONT_INS  = 4'd1;
    localparam logic [3:0] MODE_END_INS    = 4'd2;
    localparam logic [3:0] MODE_RM_SHIFT   = 4'd3;
    localparam logic [3:0] MODE_RM_SWAP    = 4'd4;
    localparam logic [3:0] MODE_RM_FRONT   = 4'd5;
    localparam logic [3:0] MODE_RM_END     = 4'd6;
    localparam logic [3:0] MODE_FIND_POS   = 4'd7;
    localparam logic [3:0] MODE_FIND_KEY   = 4'd8;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BAD_POS   = 3'd4;

    typedef struct packed {
        logic [3:0]  mode;
        logic [23:0] record_key;
        logic [31:0] record_payload;
        logic [7:0]  position;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [23:0] found_key;
        logic [31:0] found_payload;
        logic [7:0]  entry_count;
        logic        is_full;
        logic        is_empty;
    } t_out_beat;

    typedef struct packed {
        logic [23:0] key;
        logic [31:0] payload;
    } t_record;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_record          data;
    } t_store_wr;

endpackage

// ===== rtl/alt_store.sv =====
`timescale 1ns / 1ps

module alt_store (
    input  logic                           i_clk,
    input  alt_pkg::t_store_wr             i_wr,
    input  logic [alt_pkg::IDX_W-1:0]      i_rd_addr,
    output alt_pkg::t_record               o_rd_data
);

    alt_pkg::t_record r_mem [alt_pkg::CAPACITY];
    alt_pkg::t_record r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/array_list_table.sv =====
`timescale 1ns / 1ps
// operation: lookup by position goes S_LOAD, S_CAPT, S_DONE; key search, sorted insert and
//   the removes by key scan one entry a cycle through the store's single read port;
//   inserts and all removes but the one at the end then move entries one a cycle
// handshake: one beat at a time; input stalls until
//   the result sits in the output register
// reset: synchronous active low, clears the count and control; store contents stay
//   undefined and only entries below the count are ever read

module array_list_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  alt_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output alt_pkg::t_out_beat o_out_data
);

    localparam int CNT_W = alt_pkg::CNT_W;
    localparam int IDX_W = alt_pkg::IDX_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_MOVE  = 8'b0000_1000,
        S_WRITE = 8'b0001_0000,
        S_LOAD  = 8'b0010_0000,
        S_CAPT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;

    // control state
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_ptr, n_ptr;       // next read address
    logic [CNT_W-1:0] r_wptr, n_wptr;     // next move write address
    logic [CNT_W-1:0] r_left, n_left;     // moves still to issue
    logic [CNT_W-1:0] r_cptr, n_cptr;     // address of the data now in the read register
    logic [CNT_W-1:0] r_hole, n_hole;     // insert / remove position
    logic             r_up, n_up;         // move direction toward higher addresses
    logic             r_pend, n_pend;     // read data in flight is valid
    logic             r_out_valid, n_out_valid;

    // operation and result payload
    logic [3:0]         r_mode, n_mode;
    logic [23:0]        r_key, n_key;
    logic [31:0]        r_pay, n_pay;
    logic [7:0]         r_pos, n_pos;
    logic [2:0]         r_status, n_status;
    alt_pkg::t_record   r_found, n_found;
    alt_pkg::t_out_beat r_out, n_out;

    // store port
    alt_pkg::t_store_wr    wr;
    logic [IDX_W-1:0]      rd_addr;
    alt_pkg::t_record      rd_data;

    logic             in_beat;
    logic             out_free;
    logic             rd_issue;
    logic             match;
    logic             is_insert;
    logic [CNT_W-1:0] fin_count;

    alt_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_beat    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_insert  = (r_mode == alt_pkg::MODE_SORTED_INS) ||
                        (r_mode == alt_pkg::MODE_FRONT_INS) ||
                        (r_mode == alt_pkg::MODE_END_INS);

    // scan compare: sorted insert stops at the first key not smaller, searches at equal
    assign match = (r_mode == alt_pkg::MODE_SORTED_INS) ? (rd_data.key >= r_key)
                                                         : (rd_data.key == r_key);
    assign rd_issue = (r_ptr < r_count);

    // count after the finished operation
    always_comb begin
        fin_count = r_count;
        if (r_status == alt_pkg::ST_OK) begin
            unique case (r_mode) inside
                alt_pkg::MODE_SORTED_INS, alt_pkg::MODE_FRONT_INS,
                alt_pkg::MODE_END_INS: begin
                    fin_count = r_count + CNT_W'(1);
                end
                alt_pkg::MODE_RM_SHIFT, alt_pkg::MODE_RM_SWAP,
                alt_pkg::MODE_RM_FRONT, alt_pkg::MODE_RM_END: begin
                    fin_count = r_count - CNT_W'(1);
                end
                default: begin
                    fin_count = r_count;
                end
            endcase
        end
    end

    // read address: scan and move walk r_ptr, position lookup reads one entry
    always_comb begin
        if (r_state == S_LOAD) begin
            rd_addr = IDX_W'(r_pos - 8'd1);
        end else begin
            rd_addr = r_ptr[IDX_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_wptr      = r_wptr;
        n_left      = r_left;
        n_cptr      = r_cptr;
        n_hole      = r_hole;
        n_up        = r_up;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_mode      = r_mode;
        n_key       = r_key;
        n_pay       = r_pay;
        n_pos       = r_pos;
        n_status    = r_status;
        n_found     = r_found;
        n_out       = r_out;
        wr          = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_mode   = i_in_data.mode;
                    n_key    = i_in_data.record_key;
                    n_pay    = i_in_data.record_payload;
                    n_pos    = i_in_data.position;
                    n_status = alt_pkg::ST_OK;
                    n_found  = '0;
                    n_ptr    = '0;
                    unique case (i_in_data.mode) inside
                        alt_pkg::MODE_SORTED_INS, alt_pkg::MODE_FRONT_INS,
                        alt_pkg::MODE_END_INS: begin
                            if (r_count >= CNT_W'(alt_pkg::CAPACITY)) begin
                                n_status = alt_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else if (i_in_data.mode == alt_pkg::MODE_SORTED_INS) begin
                                n_state = S_SCAN;
                            end else if (i_in_data.mode == alt_pkg::MODE_FRONT_INS) begin
                                n_hole  = '0;
                                n_state = S_PREP;
                            end else begin
                                n_hole  = r_count;
                                n_state = S_PREP;
                            end
                        end
                        alt_pkg::MODE_RM_SHIFT, alt_pkg::MODE_RM_SWAP: begin
                            if (r_count == '0) begin
                                n_status = alt_pkg::ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        alt_pkg::MODE_RM_FRONT: begin
                            if (r_count == '0) begin
                                n_status = alt_pkg::ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_hole  = '0;
                                n_state = S_PREP;
                            end
                        end
                        alt_pkg::MODE_RM_END: begin
                            if (r_count == '0) begin
                                n_status = alt_pkg::ST_EMPTY;
                            end
                            n_state = S_DONE;
                        end
                        alt_pkg::MODE_FIND_POS: begin
                            if ((i_in_data.position == 8'd0) ||
                                (alt_pkg::WIDE_W'(i_in_data.position) >
                                 alt_pkg::WIDE_W'(r_count))) begin
                                n_status = alt_pkg::ST_BAD_POS;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        alt_pkg::MODE_FIND_KEY: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // one read issued and one compare made per cycle
            S_SCAN: begin
                if (r_pend && match) begin
                    n_hole = r_cptr;
                    if (r_mode == alt_pkg::MODE_FIND_KEY) begin
                        n_found = rd_data;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PREP;
                    end
                end else if (!r_pend && !rd_issue) begin
                    n_hole = r_count;
                    if (r_mode == alt_pkg::MODE_SORTED_INS) begin
                        n_state = S_PREP;
                    end else begin
                        n_status = alt_pkg::ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end else if (rd_issue) begin
                    n_ptr  = r_ptr + CNT_W'(1);
                    n_cptr = r_ptr;
                    n_pend = 1'b1;
                end
            end

            // set up the entry move for the operation
            S_PREP: begin
                n_state = S_MOVE;
                unique case (r_mode) inside
                    alt_pkg::MODE_SORTED_INS, alt_pkg::MODE_FRONT_INS,
                    alt_pkg::MODE_END_INS: begin
                        n_up   = 1'b1;
                        n_left = r_count - r_hole;
                        n_ptr  = r_count - CNT_W'(1);
                        n_wptr = r_count;
                    end
                    alt_pkg::MODE_RM_SWAP: begin
                        // last entry fills the hole
                        n_up   = 1'b0;
                        n_left = CNT_W'(1);
                        n_ptr  = r_count - CNT_W'(1);
                        n_wptr = r_hole;
                    end
                    default: begin
                        n_up   = 1'b0;
                        n_left = r_count - r_hole - CNT_W'(1);
                        n_ptr  = r_hole + CNT_W'(1);
                        n_wptr = r_hole;
                    end
                endcase
            end

            // read one entry and write the previous one each cycle
            S_MOVE: begin
                if (r_left != '0) begin
                    n_left = r_left - CNT_W'(1);
                    n_ptr  = r_up ? (r_ptr - CNT_W'(1)) : (r_ptr + CNT_W'(1));
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    wr.en   = 1'b1;
                    wr.addr = r_wptr[IDX_W-1:0];
                    wr.data = rd_data;
                    n_wptr  = r_up ? (r_wptr - CNT_W'(1)) : (r_wptr + CNT_W'(1));
                end
                if (!r_pend && (r_left == '0)) begin
                    n_state = is_insert ? S_WRITE : S_DONE;
                end
            end

            S_WRITE: begin
                wr.en           = 1'b1;
                wr.addr         = r_hole[IDX_W-1:0];
                wr.data.key     = r_key;
                wr.data.payload = r_pay;
                n_state         = S_DONE;
            end

            S_LOAD: begin
                n_state = S_CAPT;
            end

            S_CAPT: begin
                n_found = rd_data;
                n_state = S_DONE;
            end

            // result goes to the output register once it is free
            S_DONE: begin
                if (out_free) begin
                    n_count             = fin_count;
                    n_out.status        = r_status;
                    n_out.found_key     = r_found.key;
                    n_out.found_payload = r_found.payload;
                    n_out.entry_count   = 8'(fin_count);
                    n_out.is_full       = (fin_count == CNT_W'(alt_pkg::CAPACITY));
                    n_out.is_empty      = (fin_count == '0);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_wptr   <= n_wptr;
        r_left   <= n_left;
        r_cptr   <= n_cptr;
        r_hole   <= n_hole;
        r_up     <= n_up;
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_pay    <= n_pay;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/alt_checker.sv =====
`timescale 1ns / 1ps

module alt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input alt_pkg::t_out_beat o_out_data
);

    // held result beat keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat changed while stalled");

    // block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again without finishing the previous beat");

    // empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.entry_count == 8'd0)))
        else $error("empty flag disagrees with entry count");

    // full and empty never together
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.is_full && o_out_data.is_empty))
        else $error("full and empty both set");

endmodule

bind array_list_table alt_checker u_alt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
